@@ hw/rtl/slcd_pkg.sv @@
// Package with shared types, constants and result packing for the frame receiver.
package slcd_pkg;

  localparam logic [7:0] SYNC_FIRST_RESET  = 8'h55;
  localparam logic [7:0] SYNC_SECOND_RESET = 8'hAA;
  localparam logic [7:0] LENGTH_RESET      = 8'd13;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
  } sync_cfg_t;

  typedef struct packed {
    logic       frame_start;
    logic       frame_byte;
    logic [7:0] byte_index;
    logic [7:0] byte_value;
    logic       frame_done;
    logic       checksum_ok;
    logic [7:0] sender_id;
    logic [7:0] frame_kind;
    logic       overflow_abort;
  } result_t;

  // Packs every result field except frame_done, which travels as tlast.
  function automatic logic [OUT_DATA_W-1:0] pack_result(input result_t r);
    return {4'b0000, r.overflow_abort, r.frame_kind, r.sender_id, r.checksum_ok,
            r.byte_value, r.byte_index, r.frame_byte, r.frame_start};
  endfunction

endpackage

@@ hw/rtl/sync_length_checksum_deframer_unit.sv @@
// Top level of the sync-word, length-prefixed, checksummed frame receiver.
// Usage:
// The slave stream carries one received byte per transaction in s_tdata.
// For every accepted byte the master stream delivers exactly one result
// transaction describing that byte: sync detection, position in the frame,
// held sender and kind bytes, checksum verdict and overflow abort.
// m_tlast is high on the result of the byte that completes a frame.
// An accepted byte is held in the input register, goes through the frame
// update, and its result is registered into the output register and offered
// on the master side. One byte is accepted in every cycle while the master
// side takes results; the rate is set by the single update stage.
// When the receiver stalls, the result is held in the output register and
// one more byte is taken into the input register before s_tready drops.
// The sync bytes are written through cfg_we, cfg_index and cfg_data while
// the stream is idle; index 0 is the first sync byte, index 1 the second.
// Reset empties both registers, restores the sync bytes to 0x55 and 0xAA,
// leaves the receiver outside any frame and sets the stored length to 13.
module sync_length_checksum_deframer_unit
  import slcd_pkg::*;
#(
  parameter int BUFFER_SIZE = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] rx_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] frame_start, [1] frame_byte, [9:2] byte_index, [17:10] byte_value,
  // [18] checksum_ok, [26:19] sender_id, [34:27] frame_kind,
  // [35] overflow_abort, [39:36] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,   // frame_done
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [7:0]            cfg_data
);

  sync_cfg_t  cfg;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  result_t    result;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  <= SYNC_FIRST_RESET;
      cfg.sync_second <= SYNC_SECOND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  cfg.sync_first  <= cfg_data;
        CFG_SYNC_SECOND: cfg.sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  slcd_step #(
    .BUFFER_SIZE(BUFFER_SIZE)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= pack_result(result);
      m_tlast <= result.frame_done;
    end
  end

endmodule

@@ hw/rtl/slcd_step.sv @@
// Frame tracking state and the per-byte update that produces one result.
module slcd_step
  import slcd_pkg::*;
#(
  parameter int BUFFER_SIZE = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  logic [7:0] rx_byte,
  input  sync_cfg_t cfg,
  output result_t   result
);

  localparam int IW = $clog2(BUFFER_SIZE + 1);
  localparam int CW = (IW > 8) ? IW : 8;

  logic [7:0]    previous_byte, previous_byte_next;
  logic          in_frame, in_frame_next;
  logic [IW-1:0] write_index, write_index_next;
  logic [7:0]    frame_length, frame_length_next;
  logic [7:0]    running_sum, running_sum_next;
  logic [7:0]    held_sender, held_sender_next;
  logic [7:0]    held_kind, held_kind_next;

  logic          sync_hit;
  logic [IW-1:0] index_inc;
  logic [CW-1:0] index_wide;
  logic [CW-1:0] inc_wide;
  logic [7:0]    length_now;
  logic          length_hit;
  logic          buffer_hit;

  always_comb begin
    sync_hit   = !in_frame && (previous_byte == cfg.sync_first) &&
                 (rx_byte == cfg.sync_second);
    index_inc  = write_index + IW'(1);
    index_wide = CW'(write_index);
    inc_wide   = CW'(index_inc);
    length_now = (write_index == IW'(2)) ? rx_byte : frame_length;
    length_hit = (inc_wide == CW'(length_now));
    buffer_hit = (index_inc >= IW'(BUFFER_SIZE));

    previous_byte_next = previous_byte;
    in_frame_next      = in_frame;
    write_index_next   = write_index;
    frame_length_next  = frame_length;
    running_sum_next   = running_sum;
    held_sender_next   = held_sender;
    held_kind_next     = held_kind;
    result             = '0;
    result.byte_value  = rx_byte;

    if (sync_hit) begin
      in_frame_next      = 1'b1;
      write_index_next   = IW'(2);
      previous_byte_next = '0;
      running_sum_next   = cfg.sync_first + cfg.sync_second;
      held_sender_next   = '0;
      held_kind_next     = '0;
      result.frame_start = 1'b1;
      result.byte_index  = 8'd1;
    end else if (in_frame) begin
      frame_length_next = length_now;
      if (write_index == IW'(3)) begin
        held_sender_next = rx_byte;
      end
      if (write_index == IW'(4)) begin
        held_kind_next = rx_byte;
      end
      write_index_next  = index_inc;
      running_sum_next  = running_sum + rx_byte;
      result.frame_byte = 1'b1;
      result.byte_index = index_wide[7:0];
      result.sender_id  = held_sender_next;
      result.frame_kind = held_kind_next;
      if (length_hit) begin
        result.frame_done  = 1'b1;
        result.checksum_ok = (running_sum == rx_byte);
        in_frame_next      = 1'b0;
      end else if (buffer_hit) begin
        result.overflow_abort = 1'b1;
        in_frame_next         = 1'b0;
      end
    end else begin
      previous_byte_next = rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte <= '0;
      in_frame      <= 1'b0;
      write_index   <= '0;
      frame_length  <= LENGTH_RESET;
      running_sum   <= '0;
      held_sender   <= '0;
      held_kind     <= '0;
    end else if (fire) begin
      previous_byte <= previous_byte_next;
      in_frame      <= in_frame_next;
      write_index   <= write_index_next;
      frame_length  <= frame_length_next;
      running_sum   <= running_sum_next;
      held_sender   <= held_sender_next;
      held_kind     <= held_kind_next;
    end
  end

endmodule

@@ hw/rtl/slcd_checker.sv @@
// Port-level checker for the frame receiver, bound to the top level.
module slcd_checker
  import slcd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("Stalled result transaction changed or vanished.");

  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("Result transaction offered right after reset.");

  a_start_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[1] && !m_tlast && (m_tdata[9:2] == 8'd1))
    else $error("Sync completion reported with inconsistent fields.");

  a_end_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tlast || m_tdata[35] || m_tdata[18]) |->
      m_tdata[1] && !(m_tlast && m_tdata[35]) && (m_tlast || !m_tdata[18]))
    else $error("Frame end, checksum or abort flags are inconsistent.");

endmodule

bind sync_length_checksum_deframer_unit slcd_checker u_slcd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

@@ dv/testbench.sv @@
// Self-checking testbench for the sync-word, length-prefixed, checksummed frame receiver.
module testbench;
  import slcd_pkg::*;

  localparam int FRAME_BUF = 256;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_PAUSE = 4;
  localparam logic [7:0] DEFAULT_BYTES [22] = '{
    8'h00, 8'hFF, 8'h55, 8'h55, 8'hAA, 8'h06, 8'hFF, 8'h00, 8'h04,
    8'h55, 8'hAA, 8'h04, 8'h03,
    8'h55, 8'hAA, 8'h03,
    8'h55, 8'hAA, 8'h06, 8'h55, 8'hAA, 8'h04
  };
  localparam logic [7:0] ZERO_FIRST_BYTES [5] = '{8'h3C, 8'h03, 8'h3C, 8'h04, 8'h40};

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_SYNC_FIRST;
  logic [7:0]            cfg_data = '0;

  logic [7:0] sync_a;
  logic [7:0] sync_b;
  logic [7:0] prev_byte;
  logic       in_frame;
  int         wr_idx;
  logic [7:0] frm_len;
  logic [7:0] run_sum;
  logic [7:0] held_sender;
  logic [7:0] held_kind;

  result_t predicted_results[$];
  int err_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int tx_burst_left = 0;
  int rx_left = 0;
  int rx_pick;

  sync_length_checksum_deframer_unit #(
    .BUFFER_SIZE(FRAME_BUF)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void reset_receiver_model();
    sync_a = SYNC_FIRST_RESET;
    sync_b = SYNC_SECOND_RESET;
    prev_byte = '0;
    in_frame = 1'b0;
    wr_idx = 0;
    frm_len = LENGTH_RESET;
    run_sum = '0;
    held_sender = '0;
    held_kind = '0;
  endfunction

  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    r.byte_value = b;
    if (!in_frame && prev_byte == sync_a && b == sync_b) begin
      in_frame = 1'b1;
      wr_idx = 2;
      prev_byte = '0;
      run_sum = sync_a + sync_b;
      held_sender = '0;
      held_kind = '0;
      r.frame_start = 1'b1;
      r.byte_index = 8'd1;
    end else if (in_frame) begin
      case (wr_idx)
        2: frm_len = b;
        3: held_sender = b;
        4: held_kind = b;
        default: ;
      endcase
      r.frame_byte = 1'b1;
      r.byte_index = 8'(wr_idx);
      wr_idx++;
      if (wr_idx == int'(frm_len)) begin
        r.frame_done = 1'b1;
        r.checksum_ok = (run_sum == b);
        in_frame = 1'b0;
      end else if (wr_idx >= FRAME_BUF) begin
        r.overflow_abort = 1'b1;
        in_frame = 1'b0;
      end
      run_sum = run_sum + b;
      r.sender_id = held_sender;
      r.frame_kind = held_kind;
    end else begin
      prev_byte = b;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 40) begin
      $display("cycle %0d: mismatch: %s", cycle_count, what);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, predicted 0x%0h", name, got, want));
    end
  endtask

  task automatic check_result();
    result_t want;
    if (predicted_results.size() == 0) begin
      report_mismatch("result transaction with no byte pending");
    end else begin
      want = predicted_results.pop_front();
      check_field("frame_start", 8'(m_tdata[0]), 8'(want.frame_start));
      check_field("frame_byte", 8'(m_tdata[1]), 8'(want.frame_byte));
      check_field("byte_index", m_tdata[9:2], want.byte_index);
      check_field("byte_value", m_tdata[17:10], want.byte_value);
      check_field("frame_done", 8'(m_tlast), 8'(want.frame_done));
      check_field("checksum_ok", 8'(m_tdata[18]), 8'(want.checksum_ok));
      check_field("sender_id", m_tdata[26:19], want.sender_id);
      check_field("frame_kind", m_tdata[34:27], want.frame_kind);
      check_field("overflow_abort", 8'(m_tdata[35]), 8'(want.overflow_abort));
      check_field("padding", 8'(m_tdata[39:36]), 8'h00);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        check_result();
      end
      if (s_tvalid && s_tready) begin
        predicted_results.push_back(deframe_byte(s_tdata));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 3) begin
        m_tready <= 1'b1;
        rx_left <= $urandom_range(20, 120);
      end else if (rx_pick < 80) begin
        m_tready <= 1'b1;
      end else if (rx_pick < 95) begin
        m_tready <= 1'b0;
        rx_left <= $urandom_range(0, 2);
      end else begin
        m_tready <= 1'b0;
        rx_left <= $urandom_range(8, 40);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (tx_burst_left > 0) begin
      tx_burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 99);
      if (gap < 2) begin
        tx_burst_left = $urandom_range(30, 150);
        gap = 0;
      end else if (gap < 75) begin
        gap = 0;
      end else if (gap < 95) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(8, 40);
      end
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_sync(input logic idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == CFG_SYNC_FIRST) begin
      sync_a = value;
    end else begin
      sync_b = value;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Lengths below three or above the buffer run until the overflow abort.
  task automatic send_frame(input int len, input bit good);
    logic [7:0] sum;
    logic [7:0] b;
    int total;
    int pick;
    total = (len >= 3 && len <= FRAME_BUF) ? len : FRAME_BUF;
    send_byte(sync_a);
    send_byte(sync_b);
    send_byte(8'(len));
    sum = sync_a + sync_b + 8'(len);
    for (int i = 3; i < total; i++) begin
      if (i == total - 1) begin
        b = good ? sum : sum + 8'($urandom_range(1, 255));
      end else begin
        pick = $urandom_range(0, 9);
        b = (pick == 0) ? sync_a : (pick == 1) ? sync_b : 8'($urandom_range(0, 255));
      end
      send_byte(b);
      sum = sum + b;
    end
  endtask

  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_byte(sync_a);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_default_sync();
    foreach (DEFAULT_BYTES[i]) send_byte(DEFAULT_BYTES[i]);
  endtask

  // With a zero first sync byte, the cleared previous byte lets the second
  // sync byte open a new frame right after one ends.
  task automatic test_zero_first_sync();
    wait_idle();
    write_sync(CFG_SYNC_FIRST, 8'h00);
    write_sync(CFG_SYNC_SECOND, 8'h3C);
    foreach (ZERO_FIRST_BYTES[i]) send_byte(ZERO_FIRST_BYTES[i]);
  endtask

  task automatic test_overflow();
    wait_idle();
    write_sync(CFG_SYNC_FIRST, SYNC_FIRST_RESET);
    write_sync(CFG_SYNC_SECOND, SYNC_SECOND_RESET);
    send_frame(0, 1'b1);
    send_frame(2, 1'b1);
    send_frame(FRAME_BUF, 1'b1);
    send_frame(255, 1'b0);
  endtask

  task automatic test_random_traffic(input int count);
    int stop_at;
    int pick;
    int len;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      send_noise($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 1) begin
        len = $urandom_range(0, 2);
      end else if (pick < 2) begin
        len = $urandom_range(200, FRAME_BUF);
      end else if (pick < 80) begin
        len = $urandom_range(3, 16);
      end else begin
        len = $urandom_range(17, 60);
      end
      send_frame(len, $urandom_range(0, 3) != 0);
    end
  endtask

  task automatic test_sync_sweep();
    logic [7:0] firsts [6];
    logic [7:0] seconds [6];
    firsts = '{8'h55, 8'h00, 8'hFF, 8'h77, 8'h00, 8'($urandom_range(0, 255))};
    seconds = '{8'hAA, 8'hFF, 8'h00, 8'h77, 8'h00, 8'($urandom_range(0, 255))};
    foreach (firsts[i]) begin
      wait_idle();
      write_sync(CFG_SYNC_FIRST, firsts[i]);
      write_sync(CFG_SYNC_SECOND, seconds[i]);
      test_random_traffic(i == 0 ? 200 : 130);
    end
  endtask

  initial begin
    reset_receiver_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_default_sync();
    test_zero_first_sync();
    test_overflow();
    test_sync_sweep();
    wait_idle();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
